>>> rtl/ax25_header_parser_defines.svh
// assertion macros for the link frame header decoder
// used by the checker module; no other dependencies
`ifndef AX25_HEADER_PARSER_DEFINES_SVH
`define AX25_HEADER_PARSER_DEFINES_SVH

// condition in the same cycle implies consequence
`define AHP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define AHP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/ahp_pkg.sv
// types, codes and record builders for the link frame header decoder
// no dependencies
`default_nettype none
package ahp_pkg;

  // record kinds
  localparam logic [2:0] KIND_DEST    = 3'd0;
  localparam logic [2:0] KIND_SRC     = 3'd1;
  localparam logic [2:0] KIND_RPT     = 3'd2;
  localparam logic [2:0] KIND_COMP    = 3'd3;
  localparam logic [2:0] KIND_SUMMARY = 3'd4;
  localparam logic [2:0] KIND_BAD     = 3'd5;

  // command/response codes
  localparam logic [1:0] CR_UNKNOWN  = 2'd0;
  localparam logic [1:0] CR_COMMAND  = 2'd1;
  localparam logic [1:0] CR_RESPONSE = 2'd2;

  // control and pid codes
  localparam logic [7:0] CT_I     = 8'h00;
  localparam logic [7:0] CT_UI    = 8'h03;
  localparam logic [7:0] CT_FRMR  = 8'h87;
  localparam logic [7:0] CT_SABM  = 8'h2F;
  localparam logic [7:0] CT_UA    = 8'h63;
  localparam logic [7:0] PID_SEG  = 8'h08;
  localparam logic [8:0] PAY_MAX  = 9'd511;

  typedef enum logic [3:0] {
    PH_ADDR, PH_RPT, PH_CTL1, PH_CTL2, PH_PID, PH_SEG, PH_PID2, PH_PAY, PH_SKIP
  } phase_e;

  // decoded control field and frame flags
  typedef struct packed {
    logic [7:0] ctype;
    logic [6:0] ns;
    logic [6:0] nr;
    logic       pf;
    logic       valid;
    logic       pidp;
    logic       seg;
    logic       first;
  } ctl_t;

  // one result word
  typedef struct packed {
    logic [2:0]  kind;
    logic [41:0] callsign;
    logic [3:0]  ssid;
    logic [7:0]  flags;
    logic [7:0]  ctype;
    logic [6:0]  ns;
    logic [6:0]  nr;
    logic [1:0]  cr;
    logic [7:0]  pid;
    logic [23:0] extra;
    logic [8:0]  plen;
    logic        last;
  } rec_t;

  // words pushed by the decoder for one byte
  typedef struct packed {
    logic [1:0] count;
    rec_t       r0;
    rec_t       r1;
  } push_t;

  function automatic logic char_ok(input logic [6:0] c);
    return (c == 7'h20) || (c >= 7'h30 && c <= 7'h39) ||
           (c >= 7'h41 && c <= 7'h5A) || (c >= 7'h61 && c <= 7'h7A);
  endfunction

  // plain address record from the seven address bytes
  function automatic rec_t addr_rec(input logic [55:0] sh, input logic [2:0] kind,
                                    input logic ext, input logic dama,
                                    input logic [1:0] cr);
    rec_t r;
    logic ok;
    r = '0;
    ok = 1'b1;
    for (int k = 0; k < 6; k++) begin
      r.callsign[41 - 7*k -: 7] = sh[55 - 8*k -: 7];
      if (!char_ok(sh[55 - 8*k -: 7])) ok = 1'b0;
    end
    r.kind = kind;
    r.ssid = sh[4:1];
    r.flags[0] = ok;
    if (kind == KIND_RPT) r.flags[1] = sh[7];
    if (kind == KIND_SRC) begin
      r.flags[3] = ext;
      r.flags[4] = dama;
      r.cr = cr;
    end
    return r;
  endfunction

  // compressed header record
  function automatic rec_t comp_rec(input logic [55:0] sh, input logic [1:0] cr);
    rec_t r;
    r = '0;
    for (int i = 0; i < 6; i++)
      r.callsign[41 - 7*i -: 7] = {1'b0, sh[39 - 6*i -: 6]} + 7'h20;
    r.kind = KIND_COMP;
    r.ssid = sh[3:0];
    r.flags[0] = 1'b1;
    r.cr = cr;
    r.extra = {10'd0, sh[55:48], sh[47:42]};
    return r;
  endfunction

  function automatic rec_t bad_rec();
    rec_t r;
    r = '0;
    r.kind = KIND_BAD;
    return r;
  endfunction

  // frame summary record
  function automatic rec_t sum_rec(input ctl_t c, input logic ext, input logic dama,
                                   input logic [1:0] cr, input logic [7:0] pid,
                                   input logic [23:0] extra, input logic [8:0] pay);
    rec_t r;
    r = '0;
    r.kind = KIND_SUMMARY;
    r.flags = {c.first, c.seg, c.pidp, dama, ext, c.pf, 1'b0, c.valid};
    r.ctype = c.ctype;
    r.ns = c.ns;
    r.nr = c.nr;
    r.cr = cr;
    r.pid = pid;
    if (c.seg) r.extra = extra;
    else if (c.ctype == CT_FRMR && pay >= 9'd3) r.extra = extra;
    else if ((c.ctype == CT_SABM || c.ctype == CT_UA) && pay >= 9'd2)
      r.extra = (pay == 9'd2) ? extra : {8'd0, extra[23:8]};
    r.plen = pay;
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/ahp_in_if.sv
// byte channel into the header decoder
// depends on nothing
`default_nettype none
interface ahp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] frame_byte;
  logic       frame_end;
  modport source (output valid, frame_byte, frame_end, input ready);
  modport sink (input valid, frame_byte, frame_end, output ready);
endinterface
`default_nettype wire

>>> rtl/ahp_out_if.sv
// record channel out of the header decoder
// depends on nothing
`default_nettype none
interface ahp_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  record_kind;
  logic [41:0] callsign;
  logic [3:0]  ssid;
  logic [7:0]  flag_bits;
  logic [7:0]  control_type;
  logic [6:0]  seq_send;
  logic [6:0]  seq_recv;
  logic [1:0]  command_response;
  logic [7:0]  protocol_id;
  logic [23:0] extra_word;
  logic [8:0]  payload_length;
  logic        last_of_run;
  modport source (output valid, record_kind, callsign, ssid, flag_bits, control_type,
                  seq_send, seq_recv, command_response, protocol_id, extra_word,
                  payload_length, last_of_run, input ready);
  modport sink (input valid, record_kind, callsign, ssid, flag_bits, control_type,
                seq_send, seq_recv, command_response, protocol_id, extra_word,
                payload_length, last_of_run, output ready);
endinterface
`default_nettype wire

>>> rtl/ahp_decode.sv
// per-byte header decode state and record generation
// depends on ahp_pkg
`default_nettype none
module ahp_decode import ahp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 512,
  parameter int MAX_REPEATERS   = 8
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       accept_i,
  input  wire logic [7:0] byte_i,
  input  wire logic       end_i,
  output push_t           push_o
);

  localparam int PW = $clog2(MAX_FRAME_BYTES + 1);
  localparam int RW = $clog2(MAX_REPEATERS + 1);
  localparam int CW = (PW > 7) ? PW : 7;

  logic [PW-1:0] pos_q, pos_d;
  phase_e        phase_q, phase_d;
  logic [55:0]   shift_q, shift_d;
  logic          comp_q, comp_d, ext_q, ext_d, dama_q, dama_d;
  logic [1:0]    cr_q, cr_d;
  logic [RW-1:0] rc_q, rc_d;
  ctl_t          ctl_q, ctl_d;
  logic [7:0]    pid_q, pid_d;
  logic [23:0]   extra_q, extra_d;
  logic [8:0]    pay_q, pay_d;
  push_t         push;

  // next state and records for the byte at the input
  always_comb begin
    rec_t       ra, rb, rf;
    logic       va, vb, vf;
    logic       dc, sc;
    logic [CW-1:0] rpt_end;
    pos_d = pos_q; phase_d = phase_q; shift_d = shift_q; comp_d = comp_q;
    ext_d = ext_q; dama_d = dama_q; cr_d = cr_q; rc_d = rc_q; ctl_d = ctl_q;
    pid_d = pid_q; extra_d = extra_q; pay_d = pay_q;
    ra = '0; rb = '0; rf = '0; va = 1'b0; vb = 1'b0; vf = 1'b0;
    dc = 1'b0; sc = 1'b0;
    rpt_end = CW'(20) + CW'(7) * CW'(rc_q);
    push = '0;

    if (pos_q < PW'(MAX_FRAME_BYTES)) begin
      pos_d = pos_q + PW'(1);
      unique case (phase_q)
        PH_ADDR: begin
          shift_d = {shift_q[47:0], byte_i};
          if (pos_q == PW'(1) && byte_i[0]) comp_d = 1'b1;
          if (comp_d) begin
            if (pos_q == PW'(6)) begin
              cr_d = shift_d[41] ? CR_COMMAND : CR_RESPONSE;
              ra = comp_rec(shift_d, cr_d);
              va = 1'b1;
              phase_d = PH_CTL1;
            end
          end else if (pos_q == PW'(6)) begin
            ra = addr_rec(shift_d, KIND_DEST, ext_q, dama_q, cr_q);
            va = 1'b1;
            cr_d = {1'b0, byte_i[7]};
          end else if (pos_q == PW'(13)) begin
            dc = cr_q[0];
            sc = byte_i[7];
            ext_d = ~byte_i[6];
            dama_d = ~byte_i[5];
            cr_d = (dc && !sc) ? CR_COMMAND : ((sc && !dc) ? CR_RESPONSE : CR_UNKNOWN);
            ra = addr_rec(shift_d, KIND_SRC, ext_d, dama_d, cr_d);
            va = 1'b1;
            phase_d = byte_i[0] ? PH_CTL1 : PH_RPT;
          end
        end
        PH_RPT: begin
          shift_d = {shift_q[47:0], byte_i};
          if (CW'(pos_q) == rpt_end) begin
            ra = addr_rec(shift_d, KIND_RPT, ext_q, dama_q, cr_q);
            va = 1'b1;
            rc_d = rc_q + RW'(1);
            if (byte_i[0]) phase_d = PH_CTL1;
            else if (rc_d >= RW'(MAX_REPEATERS)) begin
              rb = bad_rec();
              vb = 1'b1;
              phase_d = PH_SKIP;
            end
          end
        end
        PH_CTL1: begin
          ctl_d = '0;
          if (!byte_i[0]) begin
            if (ext_q) begin
              ctl_d.ns = byte_i[7:1];
              phase_d = PH_CTL2;
            end else begin
              ctl_d.ns = {4'd0, byte_i[3:1]};
              ctl_d.nr = {4'd0, byte_i[7:5]};
              ctl_d.pf = byte_i[4];
            end
          end else if (byte_i[1]) begin
            ctl_d.ctype = byte_i & 8'hEF;
            ctl_d.pf = byte_i[4];
          end else if (ext_q) begin
            ctl_d.ctype = byte_i;
            phase_d = PH_CTL2;
          end else begin
            ctl_d.ctype = {4'd0, byte_i[3:0]};
            ctl_d.nr = {4'd0, byte_i[7:5]};
            ctl_d.pf = byte_i[4];
          end
        end
        PH_CTL2: begin
          ctl_d.nr = ctl_q.nr | byte_i[7:1];
          ctl_d.pf = ctl_q.pf | byte_i[0];
        end
        PH_PID: begin
          pid_d = byte_i;
          ctl_d.pidp = 1'b1;
          phase_d = (byte_i == PID_SEG) ? PH_SEG : PH_PAY;
        end
        PH_SEG: begin
          ctl_d.seg = 1'b1;
          extra_d = {17'd0, byte_i[6:0]};
          if (byte_i[7]) begin
            ctl_d.first = 1'b1;
            phase_d = PH_PID2;
          end else begin
            phase_d = PH_PAY;
          end
        end
        PH_PID2: begin
          pid_d = byte_i;
          phase_d = PH_PAY;
        end
        PH_PAY: begin
          if (pay_q < 9'd3 && (ctl_q.ctype == CT_FRMR || ctl_q.ctype == CT_SABM ||
                               ctl_q.ctype == CT_UA))
            extra_d = {extra_q[15:0], byte_i};
          if (pay_q < PAY_MAX) pay_d = pay_q + 9'd1;
        end
        default: ;
      endcase
      // control field complete: pick the next phase
      if ((phase_q == PH_CTL1 && phase_d == PH_CTL1) || phase_q == PH_CTL2) begin
        ctl_d.valid = 1'b1;
        phase_d = (ctl_d.ctype == CT_I || ctl_d.ctype == CT_UI) ? PH_PID : PH_PAY;
      end
    end

    // end of frame record
    if (end_i) begin
      unique case (phase_d)
        PH_CTL1: begin
          vf = 1'b1;
          if (comp_d || rc_d == '0) rf = bad_rec();
          else rf = sum_rec(ctl_d, ext_d, dama_d, cr_d, pid_d, extra_d, pay_d);
        end
        PH_PID, PH_PAY: begin
          vf = 1'b1;
          rf = sum_rec(ctl_d, ext_d, dama_d, cr_d, pid_d, extra_d, pay_d);
        end
        PH_SKIP: vf = 1'b0;
        default: begin
          vf = 1'b1;
          rf = bad_rec();
        end
      endcase
    end

    // pack up to two words in order
    if (va) begin
      push.r0 = ra;
      if (vb) begin
        push.r1 = rb;
        push.count = 2'd2;
      end else if (vf) begin
        push.r1 = rf;
        push.count = 2'd2;
      end else begin
        push.count = 2'd1;
      end
    end else if (vf) begin
      push.r0 = rf;
      push.count = 2'd1;
    end
    if (push.count == 2'd2) push.r1.last = 1'b1;
    else if (push.count == 2'd1) push.r0.last = 1'b1;
    if (!accept_i) push.count = 2'd0;
  end

  assign push_o = push;

  // decode state, cleared after each frame end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; phase_q <= PH_ADDR; shift_q <= '0; comp_q <= 1'b0;
      ext_q <= 1'b0; dama_q <= 1'b0; cr_q <= CR_UNKNOWN; rc_q <= '0;
      ctl_q <= '0; pid_q <= '0; extra_q <= '0; pay_q <= '0;
    end else if (accept_i) begin
      if (end_i) begin
        pos_q <= '0; phase_q <= PH_ADDR; shift_q <= '0; comp_q <= 1'b0;
        ext_q <= 1'b0; dama_q <= 1'b0; cr_q <= CR_UNKNOWN; rc_q <= '0;
        ctl_q <= '0; pid_q <= '0; extra_q <= '0; pay_q <= '0;
      end else begin
        pos_q <= pos_d; phase_q <= phase_d; shift_q <= shift_d; comp_q <= comp_d;
        ext_q <= ext_d; dama_q <= dama_d; cr_q <= cr_d; rc_q <= rc_d;
        ctl_q <= ctl_d; pid_q <= pid_d; extra_q <= extra_d; pay_q <= pay_d;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/ahp_rec_queue.sv
// three-entry result word queue between decoder and output channel
// depends on ahp_pkg
`default_nettype none
module ahp_rec_queue import ahp_pkg::*; (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire push_t push_i,
  input  wire logic  pop_i,
  output logic       room_o,
  output logic       valid_o,
  output rec_t       head_o
);

  rec_t       q_q [3];
  rec_t       q_d [3];
  logic [1:0] cnt_q, cnt_d;

  // room for two words after this cycle's pop
  assign room_o  = (cnt_q <= 2'd1) || (cnt_q == 2'd2 && pop_i);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = q_q[0];

  // shift on pop, append pushed words
  always_comb begin
    logic [1:0] base;
    base = pop_i ? cnt_q - 2'd1 : cnt_q;
    q_d[0] = pop_i ? q_q[1] : q_q[0];
    q_d[1] = pop_i ? q_q[2] : q_q[1];
    q_d[2] = q_q[2];
    if (push_i.count != 2'd0 && base != 2'd3) q_d[base] = push_i.r0;
    if (push_i.count == 2'd2 && base <= 2'd1) q_d[base + 2'd1] = push_i.r1;
    cnt_d = base + push_i.count;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q <= q_d;
  end

endmodule
`default_nettype wire

>>> rtl/ax25_header_parser.sv
// link frame header decoder, top level
// depends on ahp_pkg, ahp_in_if, ahp_out_if, ahp_decode, ahp_rec_queue
//
//   channel  dir  word
//   in_i     in   one frame byte with end marker
//   out_o    out  one decoded header record
//
// one byte is taken per cycle while the queue has room; the decode state updates
// at the byte's edge, and its records are written into the queue at that edge
// a byte that gives two records puts two words into the queue; the
// three-entry queue accepts a byte while at most one word remains after
// this cycle's pop, so in_i.ready follows out_o.ready within the cycle
// reset clears the decode state and empties the queue
`default_nettype none
module ax25_header_parser import ahp_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 512,
  parameter int MAX_REPEATERS   = 8
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ahp_in_if.sink    in_i,
  ahp_out_if.source out_o
);

  logic  accept, pop, room, head_valid;
  push_t push;
  rec_t  head;

  assign accept = in_i.valid & in_i.ready;
  assign pop    = out_o.valid & out_o.ready;
  assign in_i.ready = room;

  ahp_decode #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES),
    .MAX_REPEATERS  (MAX_REPEATERS)
  ) u_decode (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .accept_i(accept),
    .byte_i  (in_i.frame_byte),
    .end_i   (in_i.frame_end),
    .push_o  (push)
  );

  ahp_rec_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .room_o (room),
    .valid_o(head_valid),
    .head_o (head)
  );

  // output word fields
  assign out_o.valid            = head_valid;
  assign out_o.record_kind      = head.kind;
  assign out_o.callsign         = head.callsign;
  assign out_o.ssid             = head.ssid;
  assign out_o.flag_bits        = head.flags;
  assign out_o.control_type     = head.ctype;
  assign out_o.seq_send         = head.ns;
  assign out_o.seq_recv         = head.nr;
  assign out_o.command_response = head.cr;
  assign out_o.protocol_id      = head.pid;
  assign out_o.extra_word       = head.extra;
  assign out_o.payload_length   = head.plen;
  assign out_o.last_of_run      = head.last;

endmodule
`default_nettype wire

>>> rtl/ahp_checker.sv
// port-level checks for the header decoder, bound to the top level
// depends on ahp_pkg and ax25_header_parser_defines.svh
`default_nettype none
`include "ax25_header_parser_defines.svh"
module ahp_checker import ahp_pkg::*; (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  kind,
  input wire logic [1:0]  cr,
  input wire logic [41:0] callsign,
  input wire logic [8:0]  plen,
  input wire logic        last
);

  // a waiting word stays offered
  `AHP_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid, "word dropped while stalled")
  // only defined record kinds leave
  `AHP_ASSERT_NOW(a_kind, out_valid, kind <= KIND_BAD, "undefined record kind")
  // a bad header word is empty and always ends its run
  `AHP_ASSERT_NOW(a_bad, out_valid && kind == KIND_BAD,
                  last && callsign == '0 && plen == '0 && cr == CR_UNKNOWN,
                  "bad header word not clean")
  // address words other than source carry no command/response
  `AHP_ASSERT_NOW(a_cr, out_valid && (kind == KIND_DEST || kind == KIND_RPT),
                  cr == CR_UNKNOWN, "command/response on plain address")

endmodule

bind ax25_header_parser ahp_checker u_ahp_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .out_valid(out_o.valid),
  .out_ready(out_o.ready),
  .kind     (out_o.record_kind),
  .cr       (out_o.command_response),
  .callsign (out_o.callsign),
  .plen     (out_o.payload_length),
  .last     (out_o.last_of_run)
);
`default_nettype wire

>>> sim/ax25_header_parser_test.sv
// testbench for the link frame header decoder: random and directed frames
// checked word by word against a predictor of the header decode
// depends on ahp_pkg, ahp_in_if, ahp_out_if and ax25_header_parser
`timescale 1ns / 1ps
module ax25_header_parser_test;
  import ahp_pkg::*;

  localparam int FRAME_LIMIT = 512;
  localparam int RPT_LIMIT   = 8;
  localparam int STALL_LIMIT = 4000;
  localparam int ITEM_COUNT  = 1800;

  // bit positions of the held control word
  localparam int CW_PF    = 22;
  localparam int CW_VALID = 23;
  localparam int CW_PIDP  = 24;
  localparam int CW_SEG   = 25;
  localparam int CW_FIRST = 26;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ahp_in_if  byte_ch ();
  ahp_out_if rec_ch ();

  ax25_header_parser i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (byte_ch),
    .out_o  (rec_ch)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // decoder state mirror
  int          dec_pos;
  phase_e      dec_phase;
  logic [55:0] addr_sh;
  logic        is_comp;
  logic        ext_mode;
  logic        dama_on;
  logic [1:0]  cr_code;
  int          rpt_cnt;
  logic [31:0] ctl_word;
  logic [7:0]  pid_val;
  logic [23:0] extra_val;
  logic [8:0]  pay_cnt;

  rec_t records_due[$];
  rec_t step_recs[$];
  int   mismatches = 0;
  int   idle_cycles = 0;
  int   words_sent = 0;
  bit   calm = 1'b0;

  function automatic bit good_char(input logic [6:0] c);
    return c == 7'h20 || (c >= 7'h30 && c <= 7'h39) || (c >= 7'h41 && c <= 7'h5A) ||
           (c >= 7'h61 && c <= 7'h7A);
  endfunction

  function automatic void clear_frame();
    dec_pos = 0; dec_phase = PH_ADDR; addr_sh = '0; is_comp = 1'b0; ext_mode = 1'b0;
    dama_on = 1'b0; cr_code = CR_UNKNOWN; rpt_cnt = 0; ctl_word = '0; pid_val = '0;
    extra_val = '0; pay_cnt = '0;
  endfunction

  function automatic void push_rec(input rec_t r);
    if (step_recs.size() < 2) step_recs.push_back(r);
  endfunction

  function automatic void push_address(input logic [2:0] kind);
    rec_t r;
    bit ok;
    logic [6:0] c;
    r = '0;
    ok = 1;
    for (int k = 0; k < 6; k++) begin
      c = addr_sh[(6 - k) * 8 + 1 +: 7];
      if (!good_char(c)) ok = 0;
      r.callsign = {r.callsign[34:0], c};
    end
    r.kind = kind;
    r.ssid = addr_sh[4:1];
    r.flags[0] = ok;
    if (kind == KIND_RPT) r.flags[1] = addr_sh[7];
    if (kind == KIND_SRC) begin
      r.flags[3] = ext_mode;
      r.flags[4] = dama_on;
      r.cr = cr_code;
    end
    push_rec(r);
  endfunction

  function automatic void push_compressed();
    rec_t r;
    r = '0;
    for (int i = 0; i < 6; i++)
      r.callsign = {r.callsign[34:0], 7'h20 + {1'b0, addr_sh[34 - 6 * i +: 6]}};
    cr_code = addr_sh[41] ? CR_COMMAND : CR_RESPONSE;
    r.kind = KIND_COMP;
    r.ssid = addr_sh[3:0];
    r.flags[0] = 1'b1;
    r.cr = cr_code;
    r.extra = {10'd0, addr_sh[55:48], addr_sh[47:42]};
    push_rec(r);
  endfunction

  function automatic void push_bad();
    rec_t r;
    r = '0;
    r.kind = KIND_BAD;
    push_rec(r);
  endfunction

  function automatic void push_summary();
    rec_t r;
    logic [7:0] t;
    t = ctl_word[7:0];
    r = '0;
    r.kind = KIND_SUMMARY;
    r.flags = {ctl_word[CW_FIRST], ctl_word[CW_SEG], ctl_word[CW_PIDP], dama_on, ext_mode,
               ctl_word[CW_PF], 1'b0, ctl_word[CW_VALID]};
    r.ctype = t;
    r.ns = ctl_word[14:8];
    r.nr = ctl_word[21:15];
    r.cr = cr_code;
    r.pid = pid_val;
    if (ctl_word[CW_SEG]) r.extra = extra_val;
    else if (t == CT_FRMR && pay_cnt >= 3) r.extra = extra_val;
    else if ((t == CT_SABM || t == CT_UA) && pay_cnt >= 2)
      r.extra = (pay_cnt == 2) ? extra_val : {8'd0, extra_val[23:8]};
    r.plen = pay_cnt;
    push_rec(r);
  endfunction

  function automatic void close_control();
    ctl_word[CW_VALID] = 1'b1;
    dec_phase = (ctl_word[7:0] == CT_I || ctl_word[7:0] == CT_UI) ? PH_PID : PH_PAY;
  endfunction

  // one byte through the header decode
  function automatic void decode_byte(input logic [7:0] b);
    logic [1:0] dc, sc;
    case (dec_phase)
      PH_ADDR: begin
        addr_sh = {addr_sh[47:0], b};
        if (dec_pos == 1 && b[0]) is_comp = 1'b1;
        if (is_comp) begin
          if (dec_pos == 6) begin
            push_compressed();
            dec_phase = PH_CTL1;
          end
        end else if (dec_pos == 6) begin
          push_address(KIND_DEST);
          cr_code = {1'b0, b[7]};
        end else if (dec_pos == 13) begin
          dc = cr_code;
          sc = {1'b0, b[7]};
          ext_mode = !b[6];
          dama_on = !b[5];
          cr_code = (dc != 0 && sc == 0) ? CR_COMMAND :
                    ((sc != 0 && dc == 0) ? CR_RESPONSE : CR_UNKNOWN);
          push_address(KIND_SRC);
          dec_phase = b[0] ? PH_CTL1 : PH_RPT;
        end
      end
      PH_RPT: begin
        addr_sh = {addr_sh[47:0], b};
        if (dec_pos - 14 - 7 * rpt_cnt == 6) begin
          push_address(KIND_RPT);
          rpt_cnt++;
          if (b[0]) dec_phase = PH_CTL1;
          else if (rpt_cnt >= RPT_LIMIT) begin
            push_bad();
            dec_phase = PH_SKIP;
          end
        end
      end
      PH_CTL1: begin
        if (!b[0]) begin
          if (ext_mode) begin
            ctl_word = {17'd0, b[7:1], 8'd0};
            dec_phase = PH_CTL2;
          end else begin
            ctl_word = '0;
            ctl_word[10:8] = b[3:1];
            ctl_word[17:15] = b[7:5];
            ctl_word[CW_PF] = b[4];
            close_control();
          end
        end else if (b[1]) begin
          ctl_word = {24'd0, b & 8'hEF};
          ctl_word[CW_PF] = b[4];
          close_control();
        end else if (ext_mode) begin
          ctl_word = {24'd0, b};
          dec_phase = PH_CTL2;
        end else begin
          ctl_word = {28'd0, b[3:0]};
          ctl_word[17:15] = b[7:5];
          ctl_word[CW_PF] = b[4];
          close_control();
        end
      end
      PH_CTL2: begin
        ctl_word[21:15] = b[7:1];
        if (b[0]) ctl_word[CW_PF] = 1'b1;
        close_control();
      end
      PH_PID: begin
        pid_val = b;
        ctl_word[CW_PIDP] = 1'b1;
        dec_phase = (b == PID_SEG) ? PH_SEG : PH_PAY;
      end
      PH_SEG: begin
        ctl_word[CW_SEG] = 1'b1;
        extra_val = {17'd0, b[6:0]};
        if (b[7]) begin
          ctl_word[CW_FIRST] = 1'b1;
          dec_phase = PH_PID2;
        end else dec_phase = PH_PAY;
      end
      PH_PID2: begin
        pid_val = b;
        dec_phase = PH_PAY;
      end
      PH_PAY: begin
        if (pay_cnt < 3 && (ctl_word[7:0] == CT_FRMR || ctl_word[7:0] == CT_SABM ||
                            ctl_word[7:0] == CT_UA))
          extra_val = {extra_val[15:0], b};
        if (pay_cnt < PAY_MAX) pay_cnt++;
      end
      default: ;
    endcase
  endfunction

  // expected records for one accepted word
  function automatic void predict_word(input logic [7:0] b, input logic fin);
    step_recs.delete();
    if (dec_pos < FRAME_LIMIT) begin
      decode_byte(b);
      dec_pos++;
    end
    if (fin) begin
      case (dec_phase)
        PH_CTL1: if (is_comp || rpt_cnt == 0) push_bad(); else push_summary();
        PH_PID, PH_PAY: push_summary();
        PH_SKIP: ;
        default: push_bad();
      endcase
      clear_frame();
    end
    if (step_recs.size() > 0) step_recs[step_recs.size() - 1].last = 1'b1;
    foreach (step_recs[i]) records_due.push_back(step_recs[i]);
  endfunction

  // prediction, checking and watchdog at the rising edge
  always @(posedge clk_i) begin
    rec_t got, want;
    bit   moved;
    moved = 1'b0;
    if (rst_ni) begin
      if (byte_ch.valid && byte_ch.ready) begin
        predict_word(byte_ch.frame_byte, byte_ch.frame_end);
        moved = 1'b1;
      end
      if (rec_ch.valid && rec_ch.ready) begin
        moved = 1'b1;
        got = {rec_ch.record_kind, rec_ch.callsign, rec_ch.ssid, rec_ch.flag_bits,
               rec_ch.control_type, rec_ch.seq_send, rec_ch.seq_recv,
               rec_ch.command_response, rec_ch.protocol_id, rec_ch.extra_word,
               rec_ch.payload_length, rec_ch.last_of_run};
        if (records_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected word: %h", got);
        end else begin
          want = records_due.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch (exp/act): kind %0d/%0d call %h/%h ssid %h/%h flags %h/%h",
                       want.kind, got.kind, want.callsign, got.callsign, want.ssid, got.ssid,
                       want.flags, got.flags);
              $display("  ct %h/%h ns %0d/%0d nr %0d/%0d cr %0d/%0d pid %h/%h",
                       want.ctype, got.ctype, want.ns, got.ns, want.nr, got.nr,
                       want.cr, got.cr, want.pid, got.pid);
              $display("  extra %h/%h len %0d/%0d last %b/%b",
                       want.extra, got.extra, want.plen, got.plen, want.last, got.last);
            end
          end
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    if (calm || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 30);
  endfunction

  // receiver stalls
  initial begin
    rec_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      rec_ch.ready = (gap_len() == 0);
    end
  end

  // one word into the decoder, with a random gap first
  task automatic send_word(input logic [7:0] b, input logic fin);
    int g;
    g = gap_len();
    if (g > 0) begin
      byte_ch.valid = 1'b0;
      repeat (g) @(negedge clk_i);
    end
    byte_ch.valid = 1'b1;
    byte_ch.frame_byte = b;
    byte_ch.frame_end = fin;
    do @(posedge clk_i); while (!(byte_ch.ready && byte_ch.valid));
    words_sent++;
    @(negedge clk_i);
    byte_ch.valid = 1'b0;
  endtask

  task automatic send_frame(input logic [7:0] f[$]);
    calm = ($urandom_range(0, 4) == 0);
    foreach (f[i]) send_word(f[i], i == f.size() - 1);
  endtask

  function automatic logic [6:0] pick_char();
    case ($urandom_range(0, 9))
      0: return 7'h20;
      1, 2: return 7'h30 + 7'($urandom_range(0, 9));
      9: return 7'($urandom_range(0, 127));
      default: return 7'h41 + 7'($urandom_range(0, 25));
    endcase
  endfunction

  // seven address bytes; last byte carries ssid, top bit and end bit
  function automatic void add_address(ref logic [7:0] f[$], input logic [7:0] last);
    for (int k = 0; k < 6; k++) f.push_back({pick_char(), 1'b0});
    f.push_back(last);
  endfunction

  function automatic logic [7:0] pick_control();
    case ($urandom_range(0, 9))
      0: return {7'($urandom_range(0, 127)), 1'b0};
      1: return {6'($urandom_range(0, 63)), 2'b01};
      2: return CT_UI | {3'd0, 1'($urandom_range(0, 1)), 4'd0};
      3: return CT_SABM | {3'd0, 1'($urandom_range(0, 1)), 4'd0};
      4: return CT_UA | {3'd0, 1'($urandom_range(0, 1)), 4'd0};
      5: return CT_FRMR | {3'd0, 1'($urandom_range(0, 1)), 4'd0};
      6: return CT_I;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // well-formed frame with random content, optionally cut short
  function automatic void build_frame(ref logic [7:0] f[$], input int rpts, input bit comp,
                                      input bit may_cut);
    int plen;
    f.delete();
    if (comp) begin
      f.push_back(8'($urandom_range(0, 255)));
      f.push_back(8'($urandom_range(0, 255)) | 8'h01);
      repeat (5) f.push_back(8'($urandom_range(0, 255)));
    end else begin
      add_address(f, 8'($urandom_range(0, 255)) & 8'hFE);
      add_address(f, (8'($urandom_range(0, 255)) & 8'hFE) | {7'd0, rpts == 0});
      for (int r = 0; r < rpts; r++)
        add_address(f, (8'($urandom_range(0, 255)) & 8'hFE) | {7'd0, r == rpts - 1});
    end
    f.push_back(pick_control());
    if ($urandom_range(0, 2) == 0) f.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 3) == 0) f.push_back(PID_SEG);
    plen = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : $urandom_range(0, 6);
    repeat (plen) f.push_back(8'($urandom_range(0, 255)));
    if (may_cut && $urandom_range(0, 5) == 0) f = f[0:$urandom_range(0, f.size() - 1)];
  endfunction

  task automatic test_short_frames();
    logic [7:0] f[$];
    send_frame('{8'hFF});
    send_frame('{8'h00, 8'h01, 8'h00});
    build_frame(f, 0, 0, 0);
    send_frame(f[0:13]);
  endtask

  task automatic test_compressed();
    logic [7:0] f[$];
    send_frame('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, CT_UI, 8'hF0, 8'h55});
    build_frame(f, 0, 1, 0);
    send_frame(f);
  endtask

  task automatic test_repeaters();
    logic [7:0] f[$];
    build_frame(f, 2, 0, 0);
    send_frame(f[0:27]);
    build_frame(f, 0, 0, 0);
    f = f[0:13];
    f[13] = f[13] & 8'hFE;
    for (int r = 0; r < RPT_LIMIT + 1; r++) add_address(f, 8'h60);
    f.push_back(CT_UI);
    send_frame(f);
  endtask

  task automatic test_control_forms();
    logic [7:0] f[$];
    logic [7:0] hdr[$];
    logic [7:0] ctl[$];
    build_frame(hdr, 0, 0, 0);
    hdr = hdr[0:13];
    hdr[13] = 8'h81;
    ctl = '{CT_FRMR, CT_SABM, CT_UA, 8'h11, 8'hFE};
    foreach (ctl[i]) begin
      f = hdr;
      f.push_back(ctl[i]);
      repeat (i) f.push_back(8'($urandom_range(0, 255)));
      send_frame(f);
    end
    f = hdr;
    f.push_back(CT_I);
    f.push_back(PID_SEG);
    f.push_back(8'h85);
    f.push_back(8'hF0);
    f.push_back(8'h00);
    send_frame(f);
    f = hdr;
    f.push_back(CT_I);
    send_frame(f);
    // extended sequence mode, control cut in the middle and then complete
    hdr[13] = 8'h01;
    f = hdr;
    f.push_back(8'hFE);
    send_frame(f);
    f.push_back(8'hFF);
    f.push_back(8'hCC);
    send_frame(f);
  endtask

  task automatic test_long_frame();
    logic [7:0] f[$];
    build_frame(f, 0, 0, 0);
    f = f[0:13];
    f[13] = 8'h01 | f[13];
    f.push_back(CT_UI);
    f.push_back(8'hF0);
    repeat (FRAME_LIMIT + 20) f.push_back(8'($urandom_range(0, 255)));
    send_frame(f);
  endtask

  task automatic test_random();
    logic [7:0] f[$];
    while (words_sent < ITEM_COUNT) begin
      if ($urandom_range(0, 9) == 0) begin
        f.delete();
        repeat ($urandom_range(1, 24)) f.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_frame(f, ($urandom_range(0, 3) == 0) ? $urandom_range(1, RPT_LIMIT + 1) : 0,
                    $urandom_range(0, 4) == 0, 1'b1);
      end
      send_frame(f);
    end
  endtask

  initial begin
    byte_ch.valid = 1'b0;
    byte_ch.frame_byte = '0;
    byte_ch.frame_end = 1'b0;
    clear_frame();
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    test_short_frames();
    test_compressed();
    test_repeaters();
    test_control_forms();
    test_long_frame();
    test_random();
    while (records_due.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && records_due.size() == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
